// ===== hw/rtl/cbd_pkg.sv =====
// Shared types and constants of the collision brake decision block.
package cbd_pkg;

    // Pipelined restoring divider geometry.
    localparam int DIV_NW = 59;
    localparam int DIV_DW = 36;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MIN_GAP   = 2'd0;
    localparam t_cfg_idx CFG_MAX_DECEL = 2'd1;
    localparam t_cfg_idx CFG_TOL_TIME  = 2'd2;

    localparam logic [16:0] RST_MIN_GAP   = 17'd2000;
    localparam logic [14:0] RST_MAX_DECEL = 15'd7000;
    localparam logic [13:0] RST_TOL_TIME  = 14'd100;

    localparam logic [9:0]  K_MS = 10'd1000;
    localparam logic [20:0] K_BS = 21'd2000000;

    typedef struct packed {
        logic signed [15:0] own_accel;
        logic [16:0]        own_speed;
        logic               leader_present;
        logic signed [15:0] leader_accel;
        logic [16:0]        leader_speed;
        logic [19:0]        leader_gap;
        logic [12:0]        reaction_ms;
        logic               proj_valid;
        logic signed [15:0] proj_accel;
        logic [16:0]        proj_speed;
        logic [23:0]        proj_offset;
        logic [23:0]        own_offset;
    } t_in_item;

    typedef struct packed {
        logic        brake;
        logic [15:0] delay_ms;
    } t_out_item;

    typedef struct packed {
        logic [16:0] min_gap;
        logic [14:0] max_decel;
        logic [13:0] tolerance_time;
    } t_cfg;

    // Per-item data that rides alongside the first divider bank.
    typedef struct packed {
        logic [19:0] gap;
        logic [16:0] bv;
        logic [23:0] ooff;
        logic [23:0] poff;
        logic        pvalid;
        logic        pa_eq;
        logic        pa_neg;
        logic        fa_neg;
        logic        no_act;
        logic        stopping;
        logic        v_pos;
        logic        ttc;
    } t_side;

    typedef struct packed {
        logic [33:0] fv2;
        logic [16:0] fden;
        logic [33:0] pv2;
        logic [16:0] pden;
    } t_fwd;

    typedef struct packed {
        t_side              side;
        t_fwd               fwd;
        logic [DIV_NW-1:0]  bs_num;
        logic [DIV_DW-1:0]  bs_den;
    } t_front;

endpackage

// ===== hw/rtl/cbd_if.sv =====
// Handshake channels of the collision brake decision block.
interface cbd_item_if;
    logic               valid;
    logic               ready;
    cbd_pkg::t_in_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cbd_res_if;
    logic               valid;
    logic               ready;
    cbd_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cbd_cfg_if;
    logic                           valid;
    logic                           ready;
    cbd_pkg::t_cfg_idx              index;
    logic [cbd_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cbd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cbd_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cbd_pkg::DIV_NW-1:0]   i_num,
    input  logic [cbd_pkg::DIV_DW-1:0]   i_den,
    output logic [cbd_pkg::DIV_NW-1:0]   o_quo
);
    logic [cbd_pkg::DIV_DW-1:0] r_rem [cbd_pkg::DIV_NW];
    logic [cbd_pkg::DIV_NW-1:0] r_quo [cbd_pkg::DIV_NW];
    logic [cbd_pkg::DIV_DW-1:0] r_den [cbd_pkg::DIV_NW];

    for (genvar k = 0; k < cbd_pkg::DIV_NW; k++) begin : g_stage
        logic [cbd_pkg::DIV_DW-1:0] w_rem_in;
        logic [cbd_pkg::DIV_DW-1:0] w_den_in;
        logic [cbd_pkg::DIV_NW-1:0] w_quo_in;
        logic [cbd_pkg::DIV_DW:0]   w_sh;
        logic [cbd_pkg::DIV_DW+1:0] w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_quo_in = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
        end

        // shift in the next dividend bit, subtract if it fits
        assign w_sh   = {w_rem_in, w_quo_in[cbd_pkg::DIV_NW-1]};
        assign w_diff = {1'b0, w_sh} - {2'b00, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den_in;
                if (!w_diff[cbd_pkg::DIV_DW+1]) begin
                    r_rem[k] <= w_diff[cbd_pkg::DIV_DW-1:0];
                    r_quo[k] <= {w_quo_in[cbd_pkg::DIV_NW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_sh[cbd_pkg::DIV_DW-1:0];
                    r_quo[k] <= {w_quo_in[cbd_pkg::DIV_NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[cbd_pkg::DIV_NW-1];
endmodule

// ===== hw/rtl/cbd_front.sv =====
// Front pipeline: products, speeds after reaction and divider operands.
module cbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  cbd_pkg::t_in_item i_item,
    input  cbd_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output cbd_pkg::t_front   o_front
);
    logic [5:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign o_valid = r_v[5];

    // Stage 1: capture the item.
    cbd_pkg::t_in_item r1_item;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
        end
    end

    // Stage 2: first products and flags.
    logic signed [16:0] w2_neg_md;
    logic signed [16:0] w2_ba;
    logic signed [16:0] w2_pa;
    cbd_pkg::t_side     n2_side;
    cbd_pkg::t_fwd      n2_fwd;

    cbd_pkg::t_side     r2_side;
    cbd_pkg::t_fwd      r2_fwd;
    logic signed [29:0] r2_bart;
    logic [26:0]        r2_bvk;
    logic signed [17:0] r2_dv;
    logic signed [20:0] r2_gm;
    logic [12:0]        r2_rt;
    logic               r2_pa_gt;

    assign w2_neg_md = -$signed({2'b00, i_cfg.max_decel});
    assign w2_ba     = $signed({r1_item.own_accel[15], r1_item.own_accel});
    assign w2_pa     = $signed({r1_item.proj_accel[15], r1_item.proj_accel});

    always_comb begin
        n2_side          = '0;
        n2_side.gap      = r1_item.leader_gap;
        n2_side.bv       = r1_item.own_speed;
        n2_side.ooff     = r1_item.own_offset;
        n2_side.poff     = r1_item.proj_offset;
        n2_side.pvalid   = r1_item.proj_valid;
        n2_side.pa_eq    = (w2_pa == w2_neg_md);
        n2_side.pa_neg   = r1_item.proj_accel[15];
        n2_side.fa_neg   = r1_item.leader_accel[15];
        n2_side.no_act   = (w2_ba <= w2_neg_md) || (r1_item.own_speed == '0)
                           || !r1_item.leader_present;
        n2_side.stopping = r1_item.leader_accel[15] || (r1_item.leader_speed == '0);
        n2_fwd.fv2       = r1_item.leader_speed * r1_item.leader_speed;
        n2_fwd.fden      = {(~r1_item.leader_accel) + 16'd1, 1'b0};
        n2_fwd.pv2       = r1_item.proj_speed * r1_item.proj_speed;
        n2_fwd.pden      = {(~r1_item.proj_accel) + 16'd1, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side  <= n2_side;
            r2_fwd   <= n2_fwd;
            r2_bart  <= $signed(r1_item.own_accel) * $signed({1'b0, r1_item.reaction_ms});
            r2_bvk   <= r1_item.own_speed * cbd_pkg::K_MS;
            r2_dv    <= $signed({1'b0, r1_item.own_speed})
                        - $signed({1'b0, r1_item.leader_speed});
            r2_gm    <= $signed({1'b0, r1_item.leader_gap})
                        - $signed({4'b0000, i_cfg.min_gap});
            r2_rt    <= r1_item.reaction_ms;
            r2_pa_gt <= (w2_pa > w2_neg_md);
        end
    end

    // Stage 3: speed after reaction, relative speed products.
    cbd_pkg::t_side     r3_side;
    cbd_pkg::t_fwd      r3_fwd;
    logic signed [30:0] r3_v;
    logic [33:0]        r3_dv2;
    logic [31:0]        r3_dvmd;
    logic signed [36:0] r3_mdgm;
    logic [26:0]        r3_bvk;
    logic [12:0]        r3_rt;
    logic               r3_pa_gt;
    logic               r3_dv_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side   <= r2_side;
            r3_fwd    <= r2_fwd;
            r3_v      <= $signed({4'b0000, r2_bvk}) + 31'(r2_bart);
            r3_dv2    <= r2_dv[16:0] * r2_dv[16:0];
            r3_dvmd   <= r2_dv[16:0] * i_cfg.max_decel;
            r3_mdgm   <= r2_gm * $signed({1'b0, i_cfg.max_decel});
            r3_bvk    <= r2_bvk;
            r3_rt     <= r2_rt;
            r3_pa_gt  <= r2_pa_gt;
            r3_dv_pos <= !r2_dv[17] && (r2_dv != '0);
        end
    end

    // Stage 4: squared speed, reaction distance term, time-to-collision sides.
    logic [28:0]        w4_vu;
    logic [29:0]        w4_w;
    logic [43:0]        w4_dvk;
    logic [44:0]        w4_rdm;
    cbd_pkg::t_side     n4_side;

    cbd_pkg::t_side     r4_side;
    cbd_pkg::t_fwd      r4_fwd;
    logic [57:0]        r4_v2;
    logic [42:0]        r4_s;
    logic signed [46:0] r4_lhs;
    logic [45:0]        r4_rhs;
    logic               r4_pa_gt;
    logic               r4_dv_pos;

    assign w4_vu  = r3_v[28:0];
    assign w4_w   = {1'b0, w4_vu} + {3'b000, r3_bvk};
    assign w4_dvk = r3_dv2 * cbd_pkg::K_MS;
    assign w4_rdm = r3_rt * r3_dvmd;

    always_comb begin
        n4_side       = r3_side;
        n4_side.v_pos = !r3_v[30] && (r3_v != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side   <= n4_side;
            r4_fwd    <= r3_fwd;
            r4_v2     <= w4_vu * w4_vu;
            r4_s      <= r3_rt * w4_w;
            r4_lhs    <= r3_mdgm * $signed({1'b0, cbd_pkg::K_MS});
            r4_rhs    <= {2'b00, w4_dvk} + {1'b0, w4_rdm};
            r4_pa_gt  <= r3_pa_gt;
            r4_dv_pos <= r3_dv_pos;
        end
    end

    // Stage 5: scale by deceleration, decide the moving-leader case.
    logic [14:0]        w5_mdd;
    cbd_pkg::t_side     n5_side;

    cbd_pkg::t_side     r5_side;
    cbd_pkg::t_fwd      r5_fwd;
    logic [57:0]        r5_ms;
    logic [57:0]        r5_v2;
    logic [35:0]        r5_bsden;

    assign w5_mdd = (i_cfg.max_decel == '0) ? 15'd1 : i_cfg.max_decel;

    always_comb begin
        n5_side     = r4_side;
        n5_side.ttc = r4_dv_pos && r4_pa_gt
                      && ($signed({r4_lhs[46], r4_lhs}) < $signed({2'b00, r4_rhs}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_side  <= n5_side;
            r5_fwd   <= r4_fwd;
            r5_ms    <= w5_mdd * r4_s;
            r5_v2    <= r4_v2;
            r5_bsden <= w5_mdd * cbd_pkg::K_BS;
        end
    end

    // Stage 6: own stop distance numerator.
    cbd_pkg::t_front r6_front;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_front.side   <= r5_side;
            r6_front.fwd    <= r5_fwd;
            r6_front.bs_num <= {1'b0, r5_ms} + {1'b0, r5_v2};
            r6_front.bs_den <= r5_bsden;
        end
    end

    assign o_front = r6_front;
endmodule

// ===== hw/rtl/collision_brake_decision.sv =====
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances on one enable.
// Depth is set by two 59-stage restoring dividers in series (stop distances,
// then brake delay) plus six front stages and two decision stages.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration registers with their defaults; no clearing pass is needed.
module collision_brake_decision (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbd_item_if.sink       i_in,
    cbd_res_if.source      o_out,
    cbd_cfg_if.sink        i_cfg
);
    localparam int LAST = cbd_pkg::DIV_NW - 1;

    cbd_pkg::t_cfg r_cfg;
    logic          w_adv;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap        <= cbd_pkg::RST_MIN_GAP;
            r_cfg.max_decel      <= cbd_pkg::RST_MAX_DECEL;
            r_cfg.tolerance_time <= cbd_pkg::RST_TOL_TIME;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cbd_pkg::CFG_MIN_GAP:   r_cfg.min_gap        <= i_cfg.data;
                cbd_pkg::CFG_MAX_DECEL: r_cfg.max_decel      <= i_cfg.data[14:0];
                cbd_pkg::CFG_TOL_TIME:  r_cfg.tolerance_time <= i_cfg.data[13:0];
                default: ;
            endcase
        end
    end

    // Front stages.
    logic            w_fv;
    cbd_pkg::t_front w_front;

    cbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_front (w_front)
    );

    // First divider bank: own stop, leader stop, projected stop.
    logic [cbd_pkg::DIV_NW-1:0] w_quo_bs;
    logic [cbd_pkg::DIV_NW-1:0] w_quo_fs;
    logic [cbd_pkg::DIV_NW-1:0] w_quo_ps;

    cbd_div u_div_bs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_front.bs_num),
        .i_den (w_front.bs_den),
        .o_quo (w_quo_bs)
    );

    cbd_div u_div_fs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({25'd0, w_front.fwd.fv2}),
        .i_den ({19'd0, w_front.fwd.fden}),
        .o_quo (w_quo_fs)
    );

    cbd_div u_div_ps (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({25'd0, w_front.fwd.pv2}),
        .i_den ({19'd0, w_front.fwd.pden}),
        .o_quo (w_quo_ps)
    );

    cbd_pkg::t_side             r_d1s [cbd_pkg::DIV_NW];
    logic [cbd_pkg::DIV_NW-1:0] r_d1v;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1s[0] <= w_front.side;
            for (int k = 1; k < cbd_pkg::DIV_NW; k++) begin
                r_d1s[k] <= r_d1s[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1v <= '0;
        end else if (w_adv) begin
            r_d1v <= {r_d1v[cbd_pkg::DIV_NW-2:0], w_fv};
        end
    end

    // Decision stage 1: surplus gap and projection check.
    cbd_pkg::t_side     w_s;
    logic [32:0]        w_fs;
    logic [32:0]        w_pq;
    logic signed [39:0] w_dd;
    logic [35:0]        w_near;
    logic [35:0]        w_far;
    logic               w_pfail;

    cbd_pkg::t_side     r_q1_side;
    logic signed [39:0] r_q1_dd;
    logic               r_q1_pfail;
    logic               r_q1_v;

    assign w_s    = r_d1s[LAST];
    assign w_fs   = w_s.fa_neg ? w_quo_fs[32:0] : '0;
    assign w_pq   = w_s.pa_neg ? w_quo_ps[32:0] : '0;
    assign w_dd   = $signed({20'd0, w_s.gap}) + $signed({7'd0, w_fs})
                    - $signed({3'd0, w_quo_bs[36:0]}) - $signed({23'd0, r_cfg.min_gap});
    assign w_near = {16'd0, w_s.gap} + {3'd0, w_fs} + {12'd0, w_s.ooff};
    assign w_far  = {12'd0, w_s.poff} + {3'd0, w_pq};
    assign w_pfail = w_s.pvalid && (w_s.pa_eq || (w_s.pa_neg && (w_near > w_far)));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q1_side  <= w_s;
            r_q1_dd    <= w_dd;
            r_q1_pfail <= w_pfail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
        end else if (w_adv) begin
            r_q1_v <= r_d1v[LAST];
        end
    end

    // Decision stage 2: tolerance test, brake flag, delay operands.
    logic signed [49:0] w_kdd;
    logic [30:0]        w_tb;
    logic               w_tol_fail;
    logic               w_brake;
    logic               w_use;

    logic [30:0]        r_q2_num;
    logic [16:0]        r_q2_den;
    logic               r_q2_brake;
    logic               r_q2_v;

    assign w_kdd      = r_q1_dd * $signed({1'b0, cbd_pkg::K_MS});
    assign w_tb       = r_cfg.tolerance_time * r_q1_side.bv;
    assign w_tol_fail = w_kdd > $signed({19'd0, w_tb});
    assign w_brake    = !r_q1_side.no_act
                        && (r_q1_side.stopping
                            ? (r_q1_side.v_pos && !w_tol_fail && !r_q1_pfail)
                            : r_q1_side.ttc);
    assign w_use      = w_brake && r_q1_side.stopping && (r_q1_dd > 40'sd0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q2_num   <= w_use ? w_kdd[30:0] : '0;
            r_q2_den   <= w_brake ? r_q1_side.bv : 17'd1;
            r_q2_brake <= w_brake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_v <= 1'b0;
        end else if (w_adv) begin
            r_q2_v <= r_q1_v;
        end
    end

    // Second divider: brake delay in ms.
    logic [cbd_pkg::DIV_NW-1:0] w_quo2;

    cbd_div u_div_dl (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({28'd0, r_q2_num}),
        .i_den ({19'd0, r_q2_den}),
        .o_quo (w_quo2)
    );

    logic [cbd_pkg::DIV_NW-1:0] r_d2b;
    logic [cbd_pkg::DIV_NW-1:0] r_d2v;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d2b <= {r_d2b[cbd_pkg::DIV_NW-2:0], r_q2_brake};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2v <= '0;
        end else if (w_adv) begin
            r_d2v <= {r_d2v[cbd_pkg::DIV_NW-2:0], r_q2_v};
        end
    end

    // Output register; the pipeline keeps moving while it holds bubbles.
    logic               r_ov;
    cbd_pkg::t_out_item r_out;
    logic               w_out_load;

    assign w_out_load = !r_ov || o_out.ready;
    assign w_adv      = !r_d2v[LAST] || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= r_d2v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.brake    <= r_d2b[LAST];
            r_out.delay_ms <= (|w_quo2[cbd_pkg::DIV_NW-1:16]) ? 16'hFFFF : w_quo2[15:0];
        end
    end

    assign i_in.ready  = w_adv;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_no_brake_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.brake |-> r_out.delay_ms == '0)
        else $error("delay without brake");

    a_idle_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d2v[LAST] && !r_d2b[LAST] |-> w_quo2 == '0)
        else $error("delay divider busy for a no-brake item");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");
`endif
endmodule
